// File: sv/mrmq_pkg.sv
// ----------------------------------------------------------------------------
// Memory region map package
// Request and response types, operation codes, status codes and region type
// codes that the memory region map and its checker share.
// ----------------------------------------------------------------------------
package mrmq_pkg;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_APPEND = 3'd1;
    localparam logic [2:0] MODE_COMMIT = 3'd2;
    localparam logic [2:0] MODE_CHECK  = 3'd3;
    localparam logic [2:0] MODE_FIND   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FALSE     = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [31:0] TYPE_NONE   = 32'd0;
    localparam logic [31:0] TYPE_USABLE = 32'd1;
    localparam logic [31:0] TYPE_RES_LO = 32'd2;
    localparam logic [31:0] TYPE_RES_HI = 32'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] base;
        logic [63:0] length;
        logic [31:0] region_type;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] result_base;
        logic [63:0] result_length;
        logic [63:0] max_usable_above;
        logic [63:0] bytes_all;
        logic [63:0] bytes_usable;
        logic [63:0] bytes_reserved;
        logic [7:0]  region_count;
        logic [7:0]  usable_count;
    } rsp_t;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] length;
        logic [31:0] rtype;
    } entry_t;

endpackage

// File: sv/memory_region_map_query.sv
// ----------------------------------------------------------------------------
// Memory region map query
// Keeps a table of memory regions in one synchronous memory and answers
// commit, range check and find requests by scanning the table.
//
//   channel   | direction | handshake               | payload
//   request   | in        | req_valid / req_stall   | req  (mrmq_pkg::req_t)
//   response  | out       | rsp_valid / rsp_stall   | rsp  (mrmq_pkg::rsp_t)
//
// Clear, append and requests answered at once go from accept straight to the
// finish state and then to the output register. Commit, check and find first
// scan all N regions of the table through the single memory read port that
// delivers one entry a cycle, then pass the finish state to the output register.
// One request is in work at a time; a finished response waits in the output
// register while the next request is accepted and worked on.
// Reset clears the region count and the ready mark; the memory needs no pass.
// ----------------------------------------------------------------------------
module memory_region_map_query #(
    parameter int MAX_REGIONS = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  mrmq_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output mrmq_pkg::rsp_t  rsp
);

    import mrmq_pkg::*;

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int XW = CW + 8;
    localparam logic [CW-1:0] FULL = CW'(MAX_REGIONS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    entry_t mem [MAX_REGIONS];

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] count_reg;
    logic          ready_reg;
    logic [CW-1:0] idx_reg;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    logic [2:0]    mode_reg;
    logic          imm_reg;
    logic [1:0]    st_reg;
    logic [63:0]   q_base_reg;
    logic [63:0]   q_len_reg;
    logic [63:0]   q_end_reg;

    logic          rd_vld_reg;
    entry_t        rd_data_reg;
    logic          a_vld_reg;
    logic [63:0]   a_base_reg;
    logic [63:0]   a_len_reg;
    logic [63:0]   a_end_reg;
    logic          a_usable_reg;
    logic          a_res_reg;
    logic          b_vld_reg;
    logic          b_ok_reg;
    logic [63:0]   b_eff_reg;
    logic [63:0]   b_end_reg;
    logic          c_vld_reg;
    logic          c_ok_reg;
    logic [63:0]   c_eff_reg;
    logic [63:0]   c_len_reg;

    logic [63:0]   tot_reg;
    logic [63:0]   usa_reg;
    logic [63:0]   resv_reg;
    logic [CW-1:0] ucnt_reg;
    logic          fail_reg;
    logic [63:0]   span_base_reg;
    logic [63:0]   span_len_reg;
    logic [63:0]   max_above_reg;

    logic          accept;
    logic          is_append;
    logic          is_scan;
    logic          wr_en;
    logic          rd_en;
    logic          scan_done;
    logic          rsp_load;
    logic          b_cand;
    logic [63:0]   b_eff;
    logic [XW-1:0] count_ext;
    logic [XW-1:0] ucnt_ext;
    rsp_t          result;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_append = (req.mode == MODE_APPEND);
    assign is_scan   = (req.mode == MODE_COMMIT)
                    || (ready_reg && req.mode == MODE_FIND)
                    || (ready_reg && req.mode == MODE_CHECK && req.length != 64'd0);
    assign wr_en     = accept && is_append && (count_reg != FULL);
    assign rd_en     = (state_reg == S_SCAN) && (idx_reg < count_reg);
    assign scan_done = (idx_reg >= count_reg) && !rd_vld_reg && !a_vld_reg
                    && !b_vld_reg && !c_vld_reg;
    assign rsp_load  = (state_reg == S_FINISH) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= '{base: req.base, length: req.length,
                rtype: (req.length == 64'd0) ? TYPE_NONE : req.region_type};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            a_vld_reg  <= rd_vld_reg;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            if (rd_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (accept)
            begin
                idx_reg <= '0;
                case (req.mode)
                    MODE_CLEAR:
                    begin
                        count_reg <= '0;
                        ready_reg <= 1'b0;
                    end
                    MODE_APPEND:
                    begin
                        count_reg <= (count_reg == FULL) ? '0 : count_reg + 1'b1;
                    end
                    MODE_COMMIT:
                    begin
                        ready_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign b_cand = a_usable_reg && (a_end_reg > q_base_reg);
    assign b_eff  = (a_base_reg > q_base_reg) ? a_base_reg : q_base_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= req.mode;
            q_base_reg    <= req.base;
            q_len_reg     <= req.length;
            q_end_reg     <= req.base + req.length;
            imm_reg       <= !is_scan;
            tot_reg       <= '0;
            usa_reg       <= '0;
            resv_reg      <= '0;
            ucnt_reg      <= '0;
            fail_reg      <= 1'b0;
            span_base_reg <= '0;
            span_len_reg  <= '0;
            max_above_reg <= '0;
            if (is_append && count_reg == FULL)
            begin
                st_reg <= ST_OVERFLOW;
            end
            else if (!ready_reg && (req.mode == MODE_CHECK || req.mode == MODE_FIND))
            begin
                st_reg <= ST_NOT_READY;
            end
            else
            begin
                st_reg <= ST_OK;
            end
        end

        a_base_reg   <= rd_data_reg.base;
        a_len_reg    <= rd_data_reg.length;
        a_end_reg    <= rd_data_reg.base + rd_data_reg.length;
        a_usable_reg <= (rd_data_reg.rtype == TYPE_USABLE);
        a_res_reg    <= (rd_data_reg.rtype >= TYPE_RES_LO)
                     && (rd_data_reg.rtype <= TYPE_RES_HI);

        b_ok_reg  <= b_cand && (b_eff < a_end_reg);
        b_eff_reg <= b_eff;
        b_end_reg <= a_end_reg;

        c_ok_reg  <= b_ok_reg;
        c_eff_reg <= b_eff_reg;
        c_len_reg <= b_end_reg - b_eff_reg;

        if (a_vld_reg)
        begin
            tot_reg <= tot_reg + a_len_reg;
            if (a_usable_reg)
            begin
                usa_reg  <= usa_reg + a_len_reg;
                ucnt_reg <= ucnt_reg + 1'b1;
            end
            else if (a_res_reg)
            begin
                resv_reg <= resv_reg + a_len_reg;
            end
            if (!a_usable_reg && (q_base_reg < a_end_reg) && (a_base_reg < q_end_reg))
            begin
                fail_reg <= 1'b1;
            end
            if (b_cand && (a_len_reg > max_above_reg))
            begin
                max_above_reg <= a_len_reg;
            end
        end

        if (c_vld_reg && c_ok_reg && (c_len_reg >= q_len_reg) && (c_len_reg > span_len_reg))
        begin
            span_base_reg <= c_eff_reg;
            span_len_reg  <= c_len_reg;
        end

        if (rsp_load)
        begin
            rsp_reg <= result;
        end
    end

    assign count_ext = XW'(count_reg);
    assign ucnt_ext  = XW'(ucnt_reg);

    always_comb
    begin
        result              = '0;
        result.region_count = count_ext[7:0];
        if (imm_reg)
        begin
            result.status = st_reg;
        end
        else
        begin
            case (mode_reg)
                MODE_COMMIT:
                begin
                    result.status         = ST_OK;
                    result.bytes_all      = tot_reg;
                    result.bytes_usable   = usa_reg;
                    result.bytes_reserved = resv_reg;
                    result.usable_count   = ucnt_ext[7:0];
                end
                MODE_CHECK:
                begin
                    result.status = fail_reg ? ST_FALSE : ST_OK;
                end
                MODE_FIND:
                begin
                    result.max_usable_above = max_above_reg;
                    if (span_len_reg != 64'd0)
                    begin
                        result.status        = ST_OK;
                        result.result_base   = span_base_reg;
                        result.result_length = span_len_reg;
                    end
                    else
                    begin
                        result.status = ST_FALSE;
                    end
                end
                default:
                begin
                    result.status = st_reg;
                end
            endcase
        end
    end

endmodule

// File: sv/mrmq_checker.sv
// ----------------------------------------------------------------------------
// Memory region map checker
// Watches the ports of the memory region map and checks the handshake and
// the consistency of the response fields.
// ----------------------------------------------------------------------------
module mrmq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input mrmq_pkg::req_t  req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input mrmq_pkg::rsp_t  rsp
);

    import mrmq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("Stalled response changed or dropped.");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("A second request was accepted while one was in work.");

    a_overflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_OVERFLOW |-> rsp.region_count == 8'd0)
        else $error("Overflow response does not report an emptied table.");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_NOT_READY |->
            rsp.result_length == 64'd0 && rsp.max_usable_above == 64'd0
            && rsp.bytes_all == 64'd0)
        else $error("Not ready response carries data.");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_length != 64'd0 |-> rsp.status == ST_OK)
        else $error("Found span reported with a failing status.");

endmodule

bind memory_region_map_query mrmq_checker u_mrmq_checker (.*);

// File: sim/memory_region_map_query_checker.sv
// ----------------------------------------------------------------------------
// Memory region map checker
// Watches the request and response channels of the memory region map. Each
// accepted request is run through a behavioral copy of the region table and
// the response it should produce is queued. Each accepted response is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module memory_region_map_query_checker #(
    parameter int MAX_REGIONS = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  mrmq_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  mrmq_pkg::rsp_t  rsp,
    output int              failures,
    output int              outstanding,
    output int              checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import mrmq_pkg::*;

    entry_t regions [MAX_REGIONS];
    int     filled = 0;
    bit     ready = 1'b0;
    rsp_t   expected_rsp [$];
    int     fail_count = 0;
    int     check_count = 0;

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic rsp_t predict_map_response(input req_t r);
        rsp_t        o;
        logic [63:0] s, e, eff, efflen, qend;
        logic [63:0] span_base, span_len, max_above;
        logic [63:0] tot, usa, res;
        logic [7:0]  ucount;
        o = '0;
        case (r.mode)
            MODE_CLEAR:
            begin
                filled = 0;
                ready = 1'b0;
            end
            MODE_APPEND:
            begin
                if (filled >= MAX_REGIONS)
                begin
                    filled = 0;
                    o.status = ST_OVERFLOW;
                end
                else
                begin
                    regions[filled].base = r.base;
                    regions[filled].length = r.length;
                    regions[filled].rtype = (r.length == 0) ? TYPE_NONE : r.region_type;
                    filled++;
                end
            end
            MODE_COMMIT:
            begin
                tot = '0;
                usa = '0;
                res = '0;
                ucount = '0;
                ready = 1'b1;
                for (int i = 0; i < filled; i++)
                begin
                    tot = tot + regions[i].length;
                    if (regions[i].rtype == TYPE_USABLE)
                    begin
                        usa = usa + regions[i].length;
                        ucount++;
                    end
                    else if (regions[i].rtype >= TYPE_RES_LO && regions[i].rtype <= TYPE_RES_HI)
                    begin
                        res = res + regions[i].length;
                    end
                end
                o.bytes_all = tot;
                o.bytes_usable = usa;
                o.bytes_reserved = res;
                o.usable_count = ucount;
            end
            MODE_CHECK:
            begin
                if (!ready)
                begin
                    o.status = ST_NOT_READY;
                end
                else if (r.length != 0)
                begin
                    qend = r.base + r.length;
                    for (int i = 0; i < filled; i++)
                    begin
                        s = regions[i].base;
                        e = s + regions[i].length;
                        if (r.base < e && s < qend && regions[i].rtype != TYPE_USABLE)
                        begin
                            o.status = ST_FALSE;
                        end
                    end
                end
            end
            MODE_FIND:
            begin
                if (!ready)
                begin
                    o.status = ST_NOT_READY;
                end
                else
                begin
                    span_base = '0;
                    span_len = '0;
                    max_above = '0;
                    for (int i = 0; i < filled; i++)
                    begin
                        s = regions[i].base;
                        e = s + regions[i].length;
                        if (regions[i].rtype == TYPE_USABLE && e > r.base)
                        begin
                            if (regions[i].length > max_above)
                            begin
                                max_above = regions[i].length;
                            end
                            eff = (s > r.base) ? s : r.base;
                            if (eff < e)
                            begin
                                efflen = e - eff;
                                if (efflen >= r.length && efflen > span_len)
                                begin
                                    span_base = eff;
                                    span_len = efflen;
                                end
                            end
                        end
                    end
                    if (span_len > 0)
                    begin
                        o.result_base = span_base;
                        o.result_length = span_len;
                    end
                    else
                    begin
                        o.status = ST_FALSE;
                    end
                    o.max_usable_above = max_above;
                end
            end
            default:
            begin
            end
        endcase
        o.region_count = 8'(filled);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            filled = 0;
            ready = 1'b0;
            expected_rsp.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response accepted with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("result_base", want.result_base, rsp.result_base);
                    check_field("result_length", want.result_length, rsp.result_length);
                    check_field("max_usable_above", want.max_usable_above,
                                rsp.max_usable_above);
                    check_field("bytes_all", want.bytes_all, rsp.bytes_all);
                    check_field("bytes_usable", want.bytes_usable, rsp.bytes_usable);
                    check_field("bytes_reserved", want.bytes_reserved, rsp.bytes_reserved);
                    check_field("region_count", want.region_count, rsp.region_count);
                    check_field("usable_count", want.usable_count, rsp.usable_count);
                    check_count++;
                end
            end
            if (req_valid && !req_stall)
            begin
                expected_rsp.push_back(predict_map_response(req));
            end
        end
        failures <= fail_count;
        outstanding <= expected_rsp.size();
        checked <= check_count;
    end

endmodule

// File: sim/memory_region_map_query_test.sv
// ----------------------------------------------------------------------------
// Memory region map testbench
// Drives the memory region map with a short directed sequence and then with
// random phases of clear, append, commit, query and unused-mode requests, with
// random gaps on the request side and random stalls on the response side. A
// separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module memory_region_map_query_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mrmq_pkg::*;

    localparam int MAX_REGIONS = 128;
    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = MAX_REGIONS + 20;
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [2:0] MODE_UNUSED_LAST = 3'd7;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;
    int    failures;
    int    outstanding;
    int    checked;

    bit          no_idle = 1'b0;
    int          len_shift = 32;
    logic [63:0] cursor = '0;
    logic [63:0] placed_base [$];
    logic [63:0] placed_len [$];
    int          mode_count [8];
    int          sent_items = 0;
    int          overflow_runs = 0;

    always #4 clk = ~clk;

    memory_region_map_query #(
        .MAX_REGIONS(MAX_REGIONS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    memory_region_map_query_checker #(
        .MAX_REGIONS(MAX_REGIONS)
    ) map_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .failures(failures),
        .outstanding(outstanding),
        .checked(checked)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int draw_pause();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [63:0] scaled_length();
        return rand64() >> len_shift;
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [63:0] addr,
                                input logic [63:0] size, input logic [31:0] kind);
        int pause;
        pause = draw_pause();
        if (pause > 0)
        begin
            req_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{mode: op, base: addr, length: size, region_type: kind};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        mode_count[op]++;
        if (op <= MODE_FIND)
        begin
            sent_items++;
        end
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic append_random_region();
        logic [63:0] b;
        logic [63:0] l;
        logic [31:0] t;
        int          idx;
        case ($urandom_range(0, 19))
            0:
            begin
                b = rand64();
                l = rand64();
            end
            1, 2:
            begin
                b = cursor - (scaled_length() >> 1);
                l = scaled_length();
            end
            3:
            begin
                if (placed_base.size() > 0)
                begin
                    idx = $urandom_range(0, placed_base.size() - 1);
                    b = placed_base[idx];
                    l = placed_len[idx];
                end
                else
                begin
                    b = cursor;
                    l = scaled_length();
                end
            end
            default:
            begin
                b = ($urandom_range(0, 2) == 0) ? cursor : cursor + (scaled_length() >> 2);
                l = scaled_length();
            end
        endcase
        if ($urandom_range(0, 19) == 0)
        begin
            l = '0;
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: t = TYPE_USABLE;
            10, 11, 12, 13, 14, 15: t = $urandom_range(TYPE_RES_LO, TYPE_RES_HI);
            16: t = TYPE_NONE;
            17: t = $urandom_range(TYPE_RES_HI + 1, 255);
            default: t = $urandom;
        endcase
        cursor = b + l;
        placed_base.push_back(b);
        placed_len.push_back(l);
        send_request(MODE_APPEND, b, l, t);
    endtask

    task automatic send_random_query();
        logic [63:0] b;
        logic [63:0] l;
        int          idx;
        idx = -1;
        if (placed_base.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            idx = $urandom_range(0, placed_base.size() - 1);
            b = placed_base[idx];
            case ($urandom_range(0, 3))
                0: b = b - (scaled_length() >> 1);
                1: b = b + placed_len[idx];
                2:
                begin
                    if (placed_len[idx] != 0)
                    begin
                        b = b + rand64() % placed_len[idx];
                    end
                end
                default: b = b + 64'($urandom_range(0, 1));
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: b = '0;
                1: b = '1;
                default: b = rand64();
            endcase
        end
        case ($urandom_range(0, 6))
            0: l = '0;
            1: l = 64'($urandom_range(1, 16));
            2: l = '1;
            3: l = rand64();
            4, 5:
            begin
                if (idx >= 0)
                begin
                    l = placed_len[idx] + 64'($urandom_range(0, 2)) - 64'd1;
                end
                else
                begin
                    l = scaled_length();
                end
            end
            default: l = scaled_length();
        endcase
        send_request(($urandom_range(0, 1) != 0) ? MODE_CHECK : MODE_FIND, b, l, $urandom);
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1) != 0)
        begin
            send_request(3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                         rand64(), rand64(), $urandom);
        end
        else
        begin
            send_random_query();
        end
    endtask

    task automatic run_directed();
        send_request(MODE_FIND, '0, '0, '0);
        send_request(MODE_CHECK, 64'h1000, 64'h10, '0);
        send_request(MODE_COMMIT, '0, '0, '0);
        send_request(MODE_CHECK, 64'h1000, '0, '0);
        send_request(MODE_FIND, '0, '0, '0);
        send_request(MODE_APPEND, 64'h0, 64'h9F000, TYPE_USABLE);
        send_request(MODE_APPEND, 64'h9F000, '0, 32'h7);
        send_request(MODE_APPEND, 64'hF0000, 64'h10000, TYPE_RES_LO);
        send_request(MODE_APPEND, 64'h100000, 64'h7FF00000, TYPE_USABLE);
        send_request(MODE_APPEND, 64'h80000000, 64'h1000, TYPE_RES_LO + 32'd1);
        send_request(MODE_APPEND, 64'h80001000, 64'h1000, TYPE_RES_LO + 32'd2);
        send_request(MODE_APPEND, 64'h80002000, 64'h1000, TYPE_RES_HI);
        send_request(MODE_APPEND, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, '1);
        send_request(MODE_APPEND, 64'h1_0000_0000, 64'hFFFF_FFFF_0000_0000, TYPE_USABLE);
        send_request(MODE_APPEND, 64'h2_0000_0000, 64'h7FF00000, TYPE_USABLE);
        send_request(MODE_COMMIT, '1, '1, '1);
        send_request(MODE_CHECK, 64'h1000, 64'h1000, '0);
        send_request(MODE_CHECK, 64'h9E000, 64'h2000, '0);
        send_request(MODE_CHECK, 64'hF8000, 64'h10000, '0);
        send_request(MODE_CHECK, '1, '1, '0);
        send_request(MODE_FIND, '0, '0, '0);
        send_request(MODE_FIND, 64'h100000, '1, '0);
        send_request(MODE_FIND, '1, 64'h1, '0);
        send_request(MODE_APPEND, 64'h10_0000_0000, 64'h1_0000_0000, TYPE_USABLE);
        send_request(MODE_FIND, 64'h80000000, 64'h1000, '0);
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
        begin
            send_request(3'(m), '1, '1, '1);
        end
        send_request(MODE_CLEAR, '1, '1, '1);
        send_request(MODE_CHECK, 64'h1000, 64'h10, '0);
    endtask

    task automatic run_phase(input bit fill);
        int regions_wanted;
        int queries;
        no_idle = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 4))
            0: len_shift = 52;
            1: len_shift = 40;
            2: len_shift = 32;
            3: len_shift = 16;
            default: len_shift = 0;
        endcase
        case ($urandom_range(0, 3))
            0: cursor = '0;
            1: cursor = rand64();
            2: cursor = 64'd0 - scaled_length();
            default: cursor = rand64() >> $urandom_range(0, 63);
        endcase
        placed_base.delete();
        placed_len.delete();
        if (fill || $urandom_range(0, 5) != 0)
        begin
            send_request(MODE_CLEAR, rand64(), rand64(), $urandom);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_random_query();
        end
        if (fill)
        begin
            regions_wanted = MAX_REGIONS;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            regions_wanted = $urandom_range(13, 48);
        end
        else
        begin
            regions_wanted = $urandom_range(0, 12);
        end
        repeat (regions_wanted)
        begin
            append_random_region();
            if ($urandom_range(0, 14) == 0)
            begin
                send_noise();
            end
        end
        send_request(MODE_COMMIT, rand64(), rand64(), $urandom);
        queries = $urandom_range(4, 20);
        repeat (queries)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    if (fill)
                    begin
                        send_random_query();
                    end
                    else
                    begin
                        append_random_region();
                    end
                end
                1: send_request(MODE_COMMIT, rand64(), rand64(), $urandom);
                2: send_noise();
                default: send_random_query();
            endcase
        end
        if (fill)
        begin
            append_random_region();
            overflow_runs++;
            send_random_query();
            send_request(MODE_COMMIT, rand64(), rand64(), $urandom);
            send_random_query();
        end
        drain_responses();
    endtask

    initial
    begin
        int first_random;
        int phase;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_responses();
        first_random = sent_items;
        phase = 0;
        while (sent_items - first_random < RANDOM_ITEMS)
        begin
            run_phase(phase == 2 || $urandom_range(0, 14) == 0);
            phase++;
        end
        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Requests sent: %0d clear, %0d append, %0d commit, %0d check, %0d find, %0d %s",
                 mode_count[MODE_CLEAR], mode_count[MODE_APPEND], mode_count[MODE_COMMIT],
                 mode_count[MODE_CHECK], mode_count[MODE_FIND],
                 mode_count[MODE_UNUSED_FIRST] + mode_count[MODE_UNUSED_MID]
                 + mode_count[MODE_UNUSED_LAST], "with an unused mode.");
        $display("Responses compared: %0d, over %0d phases; table filled and overflowed %0d times.",
                 checked, phase, overflow_runs);
        if (failures == 0 && outstanding == 0)
        begin
            $display("memory_region_map_query_test: done, clean");
        end
        else
        begin
            $display("memory_region_map_query_test: done, errors");
        end
        $finish;
    end

    initial
    begin
        int hold;
        rsp_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            hold = draw_pause();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("Timed out after %0d cycles with no handshake.", IDLE_LIMIT);
        $display("memory_region_map_query_test: done, errors");
        $finish;
    end

endmodule

// File: files.f
sv/mrmq_pkg.sv
sv/memory_region_map_query.sv
sv/mrmq_checker.sv
sim/memory_region_map_query_checker.sv
sim/memory_region_map_query_test.sv
